>>> hdl/tlr_pkg.sv
package tlr_pkg;

    localparam int COORD_W     = 32;
    localparam int WIDTH_W     = 40;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FATAL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FATAL   = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_QUERY,
        OP_NOP
    } cmd_op_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] exon_start;
        logic signed [COORD_W-1:0] exon_end;
        logic                      minus_strand;
        logic signed [COORD_W-1:0] location;
        logic                      location_missing;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] ref_location;
        logic                      ref_valid;
        logic [WIDTH_W-1:0]        width_total;
    } out_item_t;

    typedef struct packed {
        logic reverse_on_minus;
        logic fatal_out_of_range;
    } cfg_t;

    typedef struct packed {
        cmd_op_t                   op;
        logic                      minus_strand;
        logic signed [COORD_W-1:0] exon_start;
        logic signed [COORD_W-1:0] exon_end;
        logic [COORD_W:0]          exon_width;
        logic                      exon_neg;
        logic [COORD_W-2:0]        location;
        logic                      location_low;
        logic                      location_missing;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] exon_start;
        logic signed [COORD_W-1:0] exon_end;
    } exon_t;

endpackage

>>> hdl/transcript_to_reference_locator_unit.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     tlr_pkg::in_item_t
// m_        out        m_valid / m_ready     tlr_pkg::out_item_t
// cfg_      in         cfg_wr_en             cfg_addr, cfg_wr_data
//
// Start, load and unused-mode words are handled without leaving the idle state; with the
// result register free, it is loaded at the same clock edge that pops the word from the queue.
// A mapped query holds the back end in its walk state, passing over the exons that lie
// before the one holding the location: the single read port gives one exon a cycle.
// Reset is synchronous and active low; the exon memory is not cleared, but the counters, flags and state are.
// Two words queue between front and back; a stalled m_ready holds the result
// and the back end waits, the front keeps taking words until the queue is full.
module transcript_to_reference_locator_unit #(
    parameter int MAX_EXONS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tlr_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tlr_pkg::out_item_t                 m_data,
    input  logic                               cfg_wr_en,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [0:0]                         cfg_wr_data
);

    tlr_pkg::cfg_t cfg_reg;
    logic          push;
    tlr_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          cmd_valid;
    logic          cmd_ready;
    tlr_pkg::cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reverse_on_minus   <= 1'b0;
            cfg_reg.fatal_out_of_range <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tlr_pkg::CFG_REVERSE: cfg_reg.reverse_on_minus   <= cfg_wr_data[0];
                tlr_pkg::CFG_FATAL:   cfg_reg.fatal_out_of_range <= cfg_wr_data[0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    tlr_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tlr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop_valid (cmd_valid),
        .pop_ready (cmd_ready),
        .pop_cmd   (cmd)
    );

    tlr_back #(
        .MAX_EXONS (MAX_EXONS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hdl/tlr_front.sv
module tlr_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  tlr_pkg::in_item_t s_data,
    input  logic              queue_full,
    output logic              push,
    output tlr_pkg::cmd_t     push_cmd
);

    logic signed [tlr_pkg::COORD_W+1:0] span;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // The exon width needs two extra bits: end - start + 1 spans a 34-bit signed range.
    assign span = (tlr_pkg::COORD_W+2)'(s_data.exon_end)
                - (tlr_pkg::COORD_W+2)'(s_data.exon_start)
                + (tlr_pkg::COORD_W+2)'(1);

    always_comb begin
        push_cmd = '0;
        case (s_data.mode)
            tlr_pkg::MODE_START: push_cmd.op = tlr_pkg::OP_START;
            tlr_pkg::MODE_LOAD:  push_cmd.op = tlr_pkg::OP_LOAD;
            tlr_pkg::MODE_QUERY: push_cmd.op = tlr_pkg::OP_QUERY;
            default:             push_cmd.op = tlr_pkg::OP_NOP;
        endcase
        push_cmd.minus_strand     = s_data.minus_strand;
        push_cmd.exon_start       = s_data.exon_start;
        push_cmd.exon_end         = s_data.exon_end;
        push_cmd.exon_width       = span[tlr_pkg::COORD_W:0];
        push_cmd.exon_neg         = span[tlr_pkg::COORD_W+1];
        push_cmd.location         = s_data.location[tlr_pkg::COORD_W-2:0];
        push_cmd.location_low     = s_data.location[tlr_pkg::COORD_W-1]
                                    || (s_data.location == '0);
        push_cmd.location_missing = s_data.location_missing;
    end

endmodule

>>> hdl/tlr_queue.sv
module tlr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tlr_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tlr_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (tlr_pkg::QUEUE_DEPTH > 1) ? $clog2(tlr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tlr_pkg::QUEUE_DEPTH + 1);

    tlr_pkg::cmd_t    slot_reg [tlr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             pop;

    assign full      = (fill_reg == CNT_W'(tlr_pkg::QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(tlr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(tlr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(tlr_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

endmodule

>>> hdl/tlr_back.sv
module tlr_back #(
    parameter int MAX_EXONS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlr_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tlr_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output tlr_pkg::out_item_t m_data
);

    localparam int IDX_W = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
    localparam int CNT_W = $clog2(MAX_EXONS + 1);
    localparam int CW    = tlr_pkg::COORD_W;
    localparam int WW    = tlr_pkg::WIDTH_W;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t             state_reg;
    logic               m_valid_reg;
    tlr_pkg::out_item_t m_data_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WW-1:0]      total_reg;
    logic               minus_reg;
    logic               bad_reg;
    logic               rev_reg;
    logic [CW-2:0]      t_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [IDX_W-1:0]   idx_reg;

    tlr_pkg::exon_t     exon_mem [MAX_EXONS];
    tlr_pkg::exon_t     rd_q_reg;

    logic               out_free;
    logic               pop;
    logic               table_full;
    logic               load_ok;
    logic               mem_we;
    logic [WW:0]        width_sum;
    logic [WW-1:0]      sat_total;
    logic               out_of_range;
    logic               walk_start;
    logic               walk_rev;
    logic [IDX_W-1:0]   first_idx;
    logic [IDX_W-1:0]   second_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [CW:0]        cur_w;
    logic               hit;
    logic               walk_done;
    logic               walk_adv;
    logic [CW-2:0]      t_off;
    logic [CW-1:0]      ref_val;
    logic               res_fire;
    tlr_pkg::out_item_t res;

    assign out_free   = !m_valid_reg || m_ready;
    assign pop        = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cmd_ready  = pop;

    assign table_full = (count_reg >= CNT_W'(MAX_EXONS));
    assign load_ok    = !cmd.exon_neg && !table_full;
    assign mem_we     = pop && (cmd.op == tlr_pkg::OP_LOAD) && load_ok;

    // The width sum saturates: one extra bit catches the carry past the top.
    assign width_sum  = {1'b0, total_reg} + (WW+1)'(cmd.exon_width);
    assign sat_total  = width_sum[WW] ? tlr_pkg::WIDTH_MAX : width_sum[WW-1:0];

    assign out_of_range = cmd.location_low || (WW'(cmd.location) > total_reg);
    assign walk_start   = pop && (cmd.op == tlr_pkg::OP_QUERY) && !cmd.location_missing
                          && !bad_reg && !out_of_range;

    assign walk_rev   = minus_reg && cfg.reverse_on_minus;
    assign first_idx  = walk_rev ? IDX_W'(count_reg - CNT_W'(1)) : '0;
    assign second_idx = walk_rev ? IDX_W'(count_reg - CNT_W'(2)) : IDX_W'(1);

    // Each walk cycle looks at the exon read in the cycle before and, unless the walk is done, fetches the next one.
    assign cur_w     = {rd_q_reg.exon_end[CW-1], rd_q_reg.exon_end}
                     - {rd_q_reg.exon_start[CW-1], rd_q_reg.exon_start}
                     + (CW+1)'(1);
    assign hit       = ((CW+1)'(t_reg) <= cur_w);
    assign walk_done = (state_reg == ST_WALK) && (hit || (left_reg == CNT_W'(1)));
    assign walk_adv  = (state_reg == ST_WALK) && !walk_done;

    assign rd_addr = walk_start ? first_idx : idx_reg;
    assign rd_en   = walk_start || walk_adv;

    assign t_off   = t_reg - (CW-1)'(1);
    assign ref_val = minus_reg ? ($unsigned(rd_q_reg.exon_end) - CW'(t_off))
                               : ($unsigned(rd_q_reg.exon_start) + CW'(t_off));

    assign res_fire = (pop && !walk_start) || (walk_done && out_free);

    always_comb begin
        res             = '0;
        res.status      = tlr_pkg::STATUS_OK;
        res.width_total = total_reg;
        if (state_reg == ST_WALK) begin
            res.ref_valid    = 1'b1;
            res.ref_location = $signed(ref_val);
        end else begin
            case (cmd.op)
                tlr_pkg::OP_START: begin
                    res.width_total = '0;
                end
                tlr_pkg::OP_LOAD: begin
                    if (cmd.exon_neg) begin
                        res.status = tlr_pkg::STATUS_BAD;
                    end else if (table_full) begin
                        res.status = tlr_pkg::STATUS_FULL;
                    end else begin
                        res.width_total = sat_total;
                    end
                end
                tlr_pkg::OP_QUERY: begin
                    if (cmd.location_missing) begin
                        res.status = tlr_pkg::STATUS_OK;
                    end else if (bad_reg) begin
                        res.status = tlr_pkg::STATUS_BAD;
                    end else if (out_of_range) begin
                        res.status = cfg.fatal_out_of_range ? tlr_pkg::STATUS_FATAL
                                                            : tlr_pkg::STATUS_RANGE;
                    end
                end
                default: begin
                    res.status = tlr_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            exon_mem[count_reg[IDX_W-1:0]] <= '{exon_start: cmd.exon_start,
                                                exon_end:   cmd.exon_end};
        end
        if (rd_en) begin
            rd_q_reg <= exon_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
            minus_reg   <= 1'b0;
            bad_reg     <= 1'b0;
        end else begin
            if (res_fire) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        case (cmd.op)
                            tlr_pkg::OP_START: begin
                                count_reg <= '0;
                                total_reg <= '0;
                                bad_reg   <= 1'b0;
                                minus_reg <= cmd.minus_strand;
                            end
                            tlr_pkg::OP_LOAD: begin
                                if (load_ok) begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    total_reg <= sat_total;
                                end else begin
                                    bad_reg <= 1'b1;
                                end
                            end
                            tlr_pkg::OP_QUERY: begin
                                if (walk_start) begin
                                    state_reg <= ST_WALK;
                                    t_reg     <= cmd.location;
                                    left_reg  <= count_reg;
                                    idx_reg   <= second_idx;
                                    rev_reg   <= walk_rev;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (walk_done) begin
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        t_reg    <= t_reg - (CW-1)'(cur_w);
                        left_reg <= left_reg - CNT_W'(1);
                        idx_reg  <= rev_reg ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_EXONS))
        else $error("exon count beyond table depth");

    a_walk_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> (left_reg != '0) && (left_reg <= count_reg))
        else $error("walk has lost track of the exons left");

    a_mapped_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.ref_valid |-> m_data_reg.status == tlr_pkg::STATUS_OK)
        else $error("mapped word carries a non-ok status");

    a_walk_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_done && !out_free |=> (state_reg == ST_WALK) && $stable(t_reg)
                                   && $stable(rd_q_reg))
        else $error("finished walk did not hold while the output was stalled");

endmodule

>>> dv/locator_checker.sv
module locator_checker #(
    parameter int MAX_EXONS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  tlr_pkg::in_item_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  tlr_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [tlr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [0:0]                    cfg_wr_data,
    output int                            mismatch_total,
    output int                            results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SPAN_LIMIT = (longint'(1) << tlr_pkg::WIDTH_W) - 1;

    // Our own copy of the exon table, counters and registers.
    longint exon_lo [MAX_EXONS];
    longint exon_hi [MAX_EXONS];
    int     exons_held;
    longint span_total;
    bit     on_minus;
    bit     table_broken;
    bit     walk_reverse;
    bit     range_fatal;
    int     fault_count;

    tlr_pkg::out_item_t expected_results [$];

    function automatic tlr_pkg::out_item_t map_word(input tlr_pkg::in_item_t w);
        tlr_pkg::out_item_t r;
        longint    s;
        longint    e;
        longint    len;
        longint    t;
        longint    mapped;
        int        k;
        int        j;
        bit        found;
        bit        rev;
        r = '0;
        r.status = tlr_pkg::STATUS_OK;
        case (w.mode)
            tlr_pkg::MODE_START: begin
                exons_held   = 0;
                span_total   = 0;
                table_broken = 1'b0;
                on_minus     = w.minus_strand;
            end
            tlr_pkg::MODE_LOAD: begin
                s   = longint'($signed(w.exon_start));
                e   = longint'($signed(w.exon_end));
                len = e - s + 1;
                if (len < 0) begin
                    r.status     = tlr_pkg::STATUS_BAD;
                    table_broken = 1'b1;
                end else if (exons_held >= MAX_EXONS) begin
                    r.status     = tlr_pkg::STATUS_FULL;
                    table_broken = 1'b1;
                end else begin
                    exon_lo[exons_held] = s;
                    exon_hi[exons_held] = e;
                    exons_held++;
                    if (len > SPAN_LIMIT - span_total) begin
                        span_total = SPAN_LIMIT;
                    end else begin
                        span_total += len;
                    end
                end
            end
            tlr_pkg::MODE_QUERY: begin
                t = longint'($signed(w.location));
                if (w.location_missing) begin
                    r.status = tlr_pkg::STATUS_OK;
                end else if (table_broken) begin
                    r.status = tlr_pkg::STATUS_BAD;
                end else if (t < 1 || t > span_total) begin
                    r.status = range_fatal ? tlr_pkg::STATUS_FATAL : tlr_pkg::STATUS_RANGE;
                end else begin
                    // Walk the exons until the remaining location falls inside one.
                    rev   = on_minus && walk_reverse;
                    found = 1'b0;
                    s     = 0;
                    e     = 0;
                    for (k = 0; k < exons_held && !found; k++) begin
                        j   = rev ? exons_held - 1 - k : k;
                        s   = exon_lo[j];
                        e   = exon_hi[j];
                        len = e - s + 1;
                        if (t <= len) begin
                            found = 1'b1;
                        end else begin
                            t -= len;
                        end
                    end
                    t -= 1;
                    mapped = on_minus ? e - t : s + t;
                    r.ref_location = mapped[tlr_pkg::COORD_W-1:0];
                    r.ref_valid    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.width_total = span_total[tlr_pkg::WIDTH_W-1:0];
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s differs, expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : track
        tlr_pkg::out_item_t want;
        if (!aresetn) begin
            exons_held   = 0;
            span_total   = 0;
            on_minus     = 1'b0;
            table_broken = 1'b0;
            walk_reverse = 1'b0;
            range_fatal  = 1'b1;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tlr_pkg::CFG_REVERSE: walk_reverse = cfg_wr_data[0];
                    tlr_pkg::CFG_FATAL:   range_fatal  = cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
            // Results are taken before the new word so that a result arriving with
            // nothing owed is caught even when a word is accepted at the same edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%0t: result word with none expected: %0h", $time, m_data);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status) begin
                        flag_field("status", 64'(want.status), 64'(m_data.status));
                    end
                    if (m_data.ref_location !== want.ref_location) begin
                        flag_field("ref_location", 64'(want.ref_location),
                                   64'(m_data.ref_location));
                    end
                    if (m_data.ref_valid !== want.ref_valid) begin
                        flag_field("ref_valid", 64'(want.ref_valid), 64'(m_data.ref_valid));
                    end
                    if (m_data.width_total !== want.width_total) begin
                        flag_field("width_total", 64'(want.width_total),
                                   64'(m_data.width_total));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(map_word(s_data));
            end
        end
        results_owed   <= expected_results.size();
        mismatch_total <= fault_count;
    end

endmodule

>>> dv/transcript_to_reference_locator_unit_tb.sv
module transcript_to_reference_locator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     EXON_SLOTS   = 64;
    localparam longint COORD_MAX    = 2147483647;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 100;
    // The longest quiet stretch of a correct run is the receiver's long hold
    // plus one full exon walk; this allows for that many times over.
    localparam int     QUIET_LIMIT  = 4000;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    tlr_pkg::in_item_t             s_data      = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    tlr_pkg::out_item_t            m_data;
    logic                          cfg_wr_en   = 1'b0;
    logic [tlr_pkg::CFG_IDX_W-1:0] cfg_addr    = '0;
    logic [0:0]                    cfg_wr_data = '0;

    int     mismatch_total;
    int     results_owed;
    bit     pace_on       = 1'b1;
    int     hold_requests = 0;
    int     words_sent    = 0;
    int     results_seen  = 0;
    int     transcripts   = 0;
    int     settings_used = 0;
    int     quiet_cycles  = 0;
    longint tx_width      = 0;
    int     tx_exons      = 0;

    always #5 aclk = ~aclk;

    transcript_to_reference_locator_unit #(
        .MAX_EXONS(EXON_SLOTS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    locator_checker #(
        .MAX_EXONS(EXON_SLOTS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .mismatch_total(mismatch_total),
        .results_owed  (results_owed)
    );

    function automatic longint draw(input longint lo, input longint hi);
        return longint'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // Any coordinate in the legal range; the most negative 32-bit value is left out.
    function automatic logic [tlr_pkg::COORD_W-1:0] any_coord();
        logic [tlr_pkg::COORD_W-1:0] v;
        v = $urandom;
        if (v == 32'h8000_0000) begin
            v = 32'h8000_0001;
        end
        return v;
    endfunction

    function automatic tlr_pkg::in_item_t blank_word(input logic [1:0] mode);
        tlr_pkg::in_item_t w;
        w.mode             = mode;
        w.exon_start       = any_coord();
        w.exon_end         = any_coord();
        w.minus_strand     = 1'($urandom_range(0, 1));
        w.location         = any_coord();
        w.location_missing = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(input tlr_pkg::in_item_t w);
        int gap;
        gap = pace_on ? int'(draw(0, 8)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_start(input bit strand);
        tlr_pkg::in_item_t w;
        w = blank_word(tlr_pkg::MODE_START);
        w.minus_strand = strand;
        send_word(w);
        tx_width = 0;
        tx_exons = 0;
        transcripts++;
    endtask

    task automatic send_exon(input longint s, input longint e);
        tlr_pkg::in_item_t w;
        w = blank_word(tlr_pkg::MODE_LOAD);
        w.exon_start = s[tlr_pkg::COORD_W-1:0];
        w.exon_end   = e[tlr_pkg::COORD_W-1:0];
        send_word(w);
        if (e - s + 1 >= 0 && tx_exons < EXON_SLOTS) begin
            tx_exons++;
            tx_width += e - s + 1;
        end
    endtask

    task automatic send_query(input longint loc, input bit missing);
        tlr_pkg::in_item_t w;
        w = blank_word(tlr_pkg::MODE_QUERY);
        w.location         = loc[tlr_pkg::COORD_W-1:0];
        w.location_missing = missing;
        send_word(w);
    endtask

    // Lower valid and wait until every word sent has produced its result.
    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic apply_setting(input bit rev, input bit fatal);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= tlr_pkg::CFG_REVERSE;
        cfg_wr_data <= rev;
        @(posedge aclk);
        cfg_addr    <= tlr_pkg::CFG_FATAL;
        cfg_wr_data <= fatal;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic gen_transcript();
        int     nex;
        int     nq;
        int     i;
        int     r;
        longint pos;
        longint s;
        longint e;
        longint len;
        longint hi;
        longint loc;
        send_start(1'($urandom_range(0, 1)));
        r   = int'(draw(0, 29));
        nex = (r == 0) ? int'(draw(62, 68)) : (r < 3) ? 0 : int'(draw(1, 6));
        r   = int'(draw(0, 9));
        pos = (r == 0) ? -COORD_MAX + draw(0, 1000)
            : (r == 1) ? COORD_MAX - draw(0, 100000) : draw(0, 1000000);
        for (i = 0; i < nex; i++) begin
            s = pos + draw(0, 500);
            if (s > COORD_MAX) begin
                s = COORD_MAX;
            end
            r = int'(draw(0, 24));
            if (r == 0) begin
                // An exon whose end lies before its start.
                e = s - 1 - draw(1, 1000);
                if (e < -COORD_MAX) begin
                    s = -COORD_MAX + 2000;
                    e = s - 1 - draw(1, 1000);
                end
            end else begin
                len = (r == 1) ? 0 : (r == 2) ? draw(1 << 20, 1 << 28) : draw(1, 300);
                if (s + len - 1 > COORD_MAX) begin
                    s = COORD_MAX - len + 1;
                end
                e   = s + len - 1;
                pos = e + 1;
            end
            send_exon(s, e);
            if (draw(0, 14) == 0) begin
                send_word(blank_word(tlr_pkg::OP_NOP));
            end
        end
        nq = int'(draw(1, 8));
        for (i = 0; i < nq; i++) begin
            hi = (tx_width < COORD_MAX) ? tx_width : COORD_MAX;
            r  = int'(draw(0, 19));
            if (r == 0) begin
                send_query(longint'($signed(any_coord())), 1'b1);
            end else if (r <= 2) begin
                case (int'(draw(0, 3)))
                    0:       loc = 0;
                    1:       loc = -draw(1, COORD_MAX);
                    2:       loc = (tx_width < COORD_MAX) ? tx_width + 1 : -COORD_MAX;
                    default: loc = -COORD_MAX;
                endcase
                send_query(loc, 1'b0);
            end else if (r <= 5) begin
                send_query((hi >= 1 && draw(0, 1) == 1) ? hi : 1, 1'b0);
            end else begin
                send_query((hi >= 1) ? draw(1, hi) : draw(0, 5), 1'b0);
            end
        end
    endtask

    // Result side: a freshly drawn stall, possibly none, for every word, and once a long hold-off
    // so that the block fills up and pushes back on its input.
    initial begin : sink
        int stall;
        int holds_served;
        holds_served = 0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = pace_on ? int'(draw(0, 8)) : 0;
            if (holds_served != hold_requests) begin
                holds_served++;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int quota;
        bit rev;
        bit fatal;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words, under the reset values of both registers.
        apply_setting(1'b0, 1'b1);
        send_query(1, 1'b0);
        send_start(1'b0);
        send_exon(100, 199);
        send_exon(-COORD_MAX, -COORD_MAX);
        send_exon(500, 499);
        send_exon(COORD_MAX - 47, COORD_MAX);
        send_query(1, 1'b0);
        send_query(101, 1'b0);
        send_query(102, 1'b0);
        send_query(149, 1'b0);
        send_query(150, 1'b0);
        send_query(0, 1'b0);
        send_query(-COORD_MAX, 1'b0);
        send_query(COORD_MAX, 1'b1);
        send_word(blank_word(tlr_pkg::OP_NOP));
        send_exon(10, 5);
        send_query(1, 1'b0);
        send_query(2, 1'b1);

        // Minus strand walked in reverse, out of range not fatal.
        quiesce();
        apply_setting(1'b1, 1'b0);
        send_start(1'b1);
        send_exon(1000, 1009);
        send_exon(2000, 2004);
        send_query(1, 1'b0);
        send_query(11, 1'b0);
        send_query(16, 1'b0);

        for (phase = 0; phase < 6; phase++) begin
            quiesce();
            case (phase)
                0:       begin rev = 1'b0; fatal = 1'b1; end
                1:       begin rev = 1'b1; fatal = 1'b0; end
                2:       begin rev = 1'b1; fatal = 1'b1; end
                3:       begin rev = 1'b0; fatal = 1'b0; end
                default: begin
                    rev   = 1'($urandom_range(0, 1));
                    fatal = 1'($urandom_range(0, 1));
                end
            endcase
            apply_setting(rev, fatal);
            pace_on = (phase != 3);
            if (phase == 1) begin
                hold_requests <= hold_requests + 1;
            end
            quota = words_sent + 85;
            while (words_sent < quota) begin
                gen_transcript();
            end
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d words over %0d transcripts under %0d register settings;",
                 words_sent, transcripts, settings_used);
        $display("%0d result words compared, %0d mismatches.", results_seen, mismatch_total);
        if (mismatch_total == 0 && results_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> transcript_to_reference_locator_unit.f
hdl/tlr_pkg.sv
hdl/tlr_front.sv
hdl/tlr_queue.sv
hdl/tlr_back.sv
hdl/transcript_to_reference_locator_unit.sv
dv/locator_checker.sv
dv/transcript_to_reference_locator_unit_tb.sv
